FILE: sv/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants for the RGBE shared-exponent encoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

  // Bit pattern of 1.0e-32f; positive floats order like their bit patterns.
  localparam logic [31:0] BLACK_LIMIT = 32'h0A4F_B11F;
  localparam logic [31:0] PINF_BITS   = 32'h7F80_0000;
  localparam logic [7:0]  EXP_ALL_ONE = 8'hFF;
  localparam logic [7:0]  BYTE_MAX    = 8'hFF;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
  } rgbe_in_t;

  typedef struct packed {
    logic [7:0] red_mantissa;
    logic [7:0] green_mantissa;
    logic [7:0] blue_mantissa;
    logic [7:0] shared_exponent;
  } rgbe_out_t;

  // Ordering key: non-positive values and NaN map to zero.
  function automatic logic [31:0] comp_key(input logic [31:0] x);
    logic nan;
    nan = (x[30:23] == EXP_ALL_ONE) && (x[22:0] != 23'd0);
    return (x[31] || nan) ? 32'd0 : x;
  endfunction

endpackage

FILE: sv/rgbe_mant.sv
// ----------------------------------------------------------------------------
// rgbe_mant
// Scales one component key by 2^(8-E): right shift, round half up, clamp.
// Shift amount is precomputed; this stage is purely combinational.
// ----------------------------------------------------------------------------
module rgbe_mant
  import rgbe_pkg::*;
(
  input  logic [31:0] key,
  input  logic [8:0]  rsh,     // right shift r = 142 + E - eu, valid when > 0
  input  logic        sat,     // shift <= 0 or infinite: 255
  output logic [7:0]  mant
);
  logic [23:0] sig;
  logic [24:0] sum;
  logic [24:0] q;
  logic [5:0]  r;

  always_comb begin
    sig  = (key[30:23] != 8'd0) ? {1'b1, key[22:0]} : {1'b0, key[22:0]};
    r    = rsh[5:0];
    mant = 8'd0;
    sum  = 25'd0;
    q    = 25'd0;
    if (key == 32'd0) begin
      mant = 8'd0;
    end else if (sat) begin
      mant = BYTE_MAX;
    end else if (rsh < 9'd26) begin
      sum  = {1'b0, sig} + (25'd1 << (r - 6'd1));
      q    = sum >> r;
      mant = (q > 25'd255) ? BYTE_MAX : q[7:0];
    end
  end
endmodule

FILE: sv/rgbe_shared_exponent_encoder.sv
// ----------------------------------------------------------------------------
// rgbe_shared_exponent_encoder
// Three linear float components in, one Radiance RGBE word out.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock (busy is low except while reset is held) and
// its RGBE word appears with out_valid after the four register stages:
// key/max, exponent, shift amounts, rounding. The receiver cannot stall; each
// result shows for one cycle only. Rounding is half away from zero; NaN and
// negatives give 0, +inf gives 255 and exponent byte 255.
module rgbe_shared_exponent_encoder
  import rgbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rgbe_in_t  in_data,
  output logic      out_valid,
  output rgbe_out_t out_data
);
  logic [3:0] vld_r;

  // stage 1: keys and max
  logic [31:0] k1_r [3];
  logic [31:0] mx1_r;
  // stage 2: exponent
  logic [31:0] k2_r [3];
  logic        blk2_r;
  logic [8:0]  e2_r;   // E + 128, range 2..256
  // stage 3: shifts
  logic [31:0] k3_r [3];
  logic [8:0]  rsh3_r [3];
  logic        sat3_r [3];
  logic        blk3_r;
  logic [7:0]  eb3_r;
  // stage 4: output
  rgbe_out_t   out_r;

  logic [31:0] k0 [3];
  logic [31:0] mx0;
  logic [7:0]  mant [3];

  // no transaction is taken while reset is held
  assign busy = ~rst_n;

  always_comb begin
    k0[0] = comp_key(in_data.red_bits);
    k0[1] = comp_key(in_data.green_bits);
    k0[2] = comp_key(in_data.blue_bits);
    mx0 = k0[0];
    if (k0[1] > mx0) mx0 = k0[1];
    if (k0[2] > mx0) mx0 = k0[2];
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    k1_r  <= k0;
    mx1_r <= mx0;

    k2_r   <= k1_r;
    blk2_r <= (mx1_r == 32'd0) || (mx1_r < BLACK_LIMIT);
    // E = mexp - 126, +inf gives E = 128; store E + 128
    e2_r   <= (mx1_r == PINF_BITS) ? 9'd256 : {1'b0, mx1_r[30:23]} + 9'd2;

    k3_r   <= k2_r;
    blk3_r <= blk2_r;
    eb3_r  <= (e2_r > 9'd255) ? BYTE_MAX : e2_r[7:0];
    for (int i = 0; i < 3; i++) begin
      // sh = eu - 142 - E = eu - 14 - (E+128); r = -sh
      logic [7:0]  eu;
      logic [10:0] rr;
      eu = (k2_r[i][30:23] != 8'd0) ? k2_r[i][30:23] : 8'd1;
      rr = {2'b0, e2_r} + 11'd14 - {3'b0, eu};
      sat3_r[i] <= (k2_r[i][30:23] == EXP_ALL_ONE) || rr[10] || (rr == 11'd0);
      rsh3_r[i] <= (rr > 11'd40) ? 9'd40 : rr[8:0];
    end

    out_r.red_mantissa    <= blk3_r ? 8'd0 : mant[0];
    out_r.green_mantissa  <= blk3_r ? 8'd0 : mant[1];
    out_r.blue_mantissa   <= blk3_r ? 8'd0 : mant[2];
    out_r.shared_exponent <= blk3_r ? 8'd0 : eb3_r;
  end

  for (genvar g = 0; g < 3; g++) begin : g_mant
    rgbe_mant u_mant (
      .key  (k3_r[g]),
      .rsh  (rsh3_r[g]),
      .sat  (sat3_r[g]),
      .mant (mant[g])
    );
  end

  assign out_valid = vld_r[3];
  assign out_data  = out_r;

  // checks
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid) else $error("result lost");
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.shared_exponent == 8'd0 |->
      out_data.red_mantissa == 8'd0 && out_data.green_mantissa == 8'd0 &&
      out_data.blue_mantissa == 8'd0) else $error("black pixel not zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy) else $error("busy raised");
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed float RGB pixels, then random bursts, into the RGBE encoder, predicts
// each RGBE word from the float bit patterns and checks results in order.
// ----------------------------------------------------------------------------

// Scoreboard: holds predicted RGBE words, checks results in arrival order.
class rgbe_scoreboard;
  rgbe_pkg::rgbe_out_t pending_words[$];
  int unsigned         mismatch_cnt;

  // Positive values keep their bits; negatives and NaN order as zero.
  static function logic [31:0] order_key(logic [31:0] x);
    if (x[31]) return 32'd0;
    if (x[30:23] == 8'hFF && x[22:0] != 23'd0) return 32'd0;
    return x;
  endfunction

  // Scale by 2^(8-E), round half away from zero, clamp to a byte.
  static function logic [7:0] scale_comp(logic [31:0] key, int shared_e);
    logic [63:0] sig;
    logic [63:0] q;
    int          eu;
    int          sh;
    if (key == 32'd0) return 8'd0;
    if (key[30:23] == 8'hFF) return 8'hFF;
    sig = (key[30:23] != 8'd0) ? {40'd0, 1'b1, key[22:0]} : {41'd0, key[22:0]};
    eu  = (key[30:23] != 8'd0) ? int'(key[30:23]) : 1;
    sh  = eu - 142 - shared_e;
    if (sh >= 0) return 8'hFF;
    if (-sh >= 40) return 8'd0;
    q = (sig + (64'd1 << (-sh - 1))) >> (-sh);
    return (q > 64'd255) ? 8'hFF : q[7:0];
  endfunction

  static function rgbe_pkg::rgbe_out_t encode_pixel(rgbe_pkg::rgbe_in_t px);
    rgbe_pkg::rgbe_out_t w;
    logic [31:0] kr, kg, kb, mx;
    int          e;
    kr = order_key(px.red_bits);
    kg = order_key(px.green_bits);
    kb = order_key(px.blue_bits);
    mx = kr;
    if (kg > mx) mx = kg;
    if (kb > mx) mx = kb;
    w = '0;
    // Black pixel: below 1e-32 (positive floats order like their bits)
    if (mx == 32'd0 || (mx != rgbe_pkg::PINF_BITS && mx < rgbe_pkg::BLACK_LIMIT))
      return w;
    e = (mx == rgbe_pkg::PINF_BITS) ? 128 : int'(mx[30:23]) - 126;
    w.red_mantissa    = scale_comp(kr, e);
    w.green_mantissa  = scale_comp(kg, e);
    w.blue_mantissa   = scale_comp(kb, e);
    w.shared_exponent = (e + 128 > 255) ? 8'hFF : ((e + 128 < 0) ? 8'd0 : 8'(e + 128));
    return w;
  endfunction

  function void note_pixel(rgbe_pkg::rgbe_in_t px);
    pending_words.push_back(encode_pixel(px));
  endfunction

  function void check_word(rgbe_pkg::rgbe_out_t got);
    rgbe_pkg::rgbe_out_t exp_w;
    if (pending_words.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_w = pending_words.pop_front();
    if (got.red_mantissa != exp_w.red_mantissa
        || got.green_mantissa != exp_w.green_mantissa
        || got.blue_mantissa != exp_w.blue_mantissa
        || got.shared_exponent != exp_w.shared_exponent) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch: expected r=%h g=%h b=%h e=%h, got r=%h g=%h b=%h e=%h",
                 exp_w.red_mantissa, exp_w.green_mantissa, exp_w.blue_mantissa,
                 exp_w.shared_exponent, got.red_mantissa, got.green_mantissa,
                 got.blue_mantissa, got.shared_exponent);
    end
  endfunction
endclass

module tb_top;
  import rgbe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PIXELS = 1330;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  rgbe_in_t  in_data;
  logic      out_valid;
  rgbe_out_t out_data;

  rgbe_scoreboard sb;
  int unsigned    cycle_cnt = 0;

  rgbe_shared_exponent_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result monitor and cycle guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid) sb.check_word(out_data);
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Random float component biased toward interesting classes
  function automatic logic [31:0] rand_comp(int unsigned base_exp);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 15))
      0:       v[30:23] = 8'hFF;
      1:       v[30:23] = 8'h00;
      2:       v[30:0]  = 31'd0;
      3, 4:    ;
      default: v[30:23] = 8'(base_exp + $urandom_range(0, 12) - 10);
    endcase
    if ($urandom_range(0, 5) != 0) v[31] = 1'b0;
    return v;
  endfunction

  // Send one pixel; hold start until the encoder takes it
  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    rgbe_in_t px;
    px = '{red_bits: r, green_bits: g, blue_bits: b};
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic idle_gap(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned burst;
    int unsigned sent;
    int unsigned be;
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: black, threshold, extremes, specials, rounding
    send_pixel(32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    send_pixel(BLACK_LIMIT, 32'd0, 32'd0);
    send_pixel(BLACK_LIMIT - 1, 32'h0000_0001, 32'h0A00_0000);
    send_pixel(32'h3F80_0000, 32'h3F00_0000, 32'h3E80_0000);
    send_pixel(32'h7F7F_FFFF, 32'h7F00_0000, 32'h0000_0000);
    send_pixel(PINF_BITS, 32'h3F80_0000, 32'hFF80_0000);
    send_pixel(32'h7FC0_0000, 32'h7F80_0001, 32'h3F80_0000);
    send_pixel(32'hFFFF_FFFF, 32'h3F7F_FFFF, 32'hBF80_0000);
    send_pixel(32'h3F7F_8000, 32'h3F7F_7FFF, 32'h3B00_0000);
    send_pixel(32'h3C00_0000, 32'h3BFF_FFFF, 32'h3B80_0000);
    send_pixel(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(32'h0080_0000, 32'h007F_FFFF, 32'h0A50_0000);
    send_pixel(32'h4B7F_FFFF, 32'h0000_0001, 32'h5555_5555);
    send_pixel(32'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();

    // Random bursts with gaps
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      burst = $urandom_range(1, 40);
      while (burst != 0 && sent < RANDOM_PIXELS) begin
        be = $urandom_range(20, 250);
        send_pixel(rand_comp(be), rand_comp(be), rand_comp(be));
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 9));
    end
    drain_results();
    repeat (10) @(posedge clk);

    if (sb.mismatch_cnt == 0 && sb.pending_words.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
sv/rgbe_pkg.sv
sv/rgbe_mant.sv
sv/rgbe_shared_exponent_encoder.sv
tb/sv/tb_top.sv
